FILE: rtl/hpt_pkg.sv
// Shared constants, codes, command/status structs and helpers for the histogram percentile table.
package hpt_pkg;

	localparam int LEVELS     = 16384;
	localparam int COUNT_BITS = 24;
	localparam int LEVEL_W    = 14;
	localparam int ADDR_W     = $clog2(LEVELS);
	localparam int PCT_W      = 7;
	localparam int STATUS_W   = 2;
	localparam int NUM_W      = COUNT_BITS + PCT_W;
	localparam int PCT_SCALE  = 100;
	localparam int QK_W       = $clog2(PCT_W);

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_EMPTY     = 2'd2
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;    // latch level of an accepted transaction
		logic    sweep_clr;  // restart sweep counter and running sum
		logic    hist_clr;   // drop integrated flag and total
		logic    clr_wr;     // write zero at sweep address, advance
		logic    add_wr;     // write incremented bin at level
		logic    fin_rd;     // read at sweep address
		logic    fin_wr;     // write running sum at sweep address, advance
		logic    div_load;   // load scaled cumulative count into divider
		logic    div_step;   // one quotient bit
		logic    res_set;    // latch result status
		status_t res_code;
		logic    out_load;   // move result into output register
	} hpt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic integrated;
		logic total_zero;
		logic level_ok;
		logic div_last;
		logic out_free;
	} hpt_sts_t;

	function automatic count_t sat_add(input count_t a, input count_t b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
	endfunction

endpackage

FILE: rtl/hpt_ctrl.sv
// Controller state machine: sequences clear, add, finish and query transactions.
module hpt_ctrl import hpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] command,
	input  hpt_sts_t   sts,
	output hpt_cmd_t   cmd,
	output logic       req_stall
);

	typedef enum logic [9:0] {
		S_CLR    = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_ADD_RD = 10'b00_0000_0100,
		S_ADD_WR = 10'b00_0000_1000,
		S_FIN_RD = 10'b00_0001_0000,
		S_FIN_WR = 10'b00_0010_0000,
		S_Q_RD   = 10'b00_0100_0000,
		S_Q_MUL  = 10'b00_1000_0000,
		S_DIV    = 10'b01_0000_0000,
		S_RESP   = 10'b10_0000_0000
	} state_t;

	state_t    state_q;
	state_t    state_nxt;
	cmd_code_t code;

	assign code      = cmd_code_t'(command);
	assign req_stall = (state_q != S_IDLE);

	// State register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res_code = ST_OK;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.sweep_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (code)
						CMD_CLEAR: begin
							cmd.sweep_clr = 1'b1;
							cmd.hist_clr  = 1'b1;
							state_nxt     = S_CLR;
						end
						CMD_ADD: begin
							if (!sts.integrated && sts.level_ok) state_nxt = S_ADD_RD;
						end
						CMD_FINISH: begin
							if (!sts.integrated) begin
								cmd.sweep_clr = 1'b1;
								state_nxt     = S_FIN_RD;
							end
						end
						CMD_QUERY: begin
							priority if (!sts.integrated) begin
								cmd.res_set  = 1'b1;
								cmd.res_code = ST_NOT_READY;
								state_nxt    = S_RESP;
							end else if (sts.total_zero) begin
								cmd.res_set  = 1'b1;
								cmd.res_code = ST_EMPTY;
								state_nxt    = S_RESP;
							end else begin
								state_nxt = S_Q_RD;
							end
						end
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			// Bin read is issued by the datapath from the latched level
			S_ADD_RD: state_nxt = S_ADD_WR;
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_nxt  = S_IDLE;
			end
			S_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_nxt  = S_FIN_WR;
			end
			S_FIN_WR: begin
				cmd.fin_wr = 1'b1;
				state_nxt  = sts.sweep_last ? S_IDLE : S_FIN_RD;
			end
			S_Q_RD: state_nxt = S_Q_MUL;
			S_Q_MUL: begin
				cmd.div_load = 1'b1;
				state_nxt    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_nxt    = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLR;
		endcase
	end

endmodule

FILE: rtl/hpt_dp.sv
// Datapath: bin memory, sweep counter, running sum, percentile divider, output register.
module hpt_dp import hpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LEVEL_W-1:0]  level,
	input  hpt_cmd_t            cmd,
	output hpt_sts_t            sts,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output logic [PCT_W-1:0]    percent,
	output logic [STATUS_W-1:0] status
);

	count_t           mem [LEVELS];
	count_t           rd_q;
	addr_t            rd_addr;
	addr_t            wr_addr;
	count_t           wr_data;
	logic             wr_en;
	addr_t            level_q;
	addr_t            sweep_q;
	count_t           acc_q;
	count_t           acc_nxt;
	count_t           total_q;
	logic             integrated_q;
	logic             in_range;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] trial;
	logic             ge;
	logic [PCT_W-1:0] quo_q;
	logic [QK_W-1:0]  qk_q;
	status_t          res_status_q;
	logic             rsp_valid_q;
	logic [PCT_W-1:0] percent_q;
	status_t          status_q;

	// Level range check and clamp to the top bin
	assign in_range = (32'(level) < 32'(LEVELS));

	always_ff @(posedge clk) begin
		if (cmd.capture) level_q <= in_range ? ADDR_W'(level) : ADDR_W'(LEVELS - 1);
	end

	// Bin memory: one write and one registered read per cycle
	assign rd_addr = cmd.fin_rd ? sweep_q : level_q;
	assign acc_nxt = sat_add(acc_q, rd_q);
	assign wr_en   = cmd.clr_wr | cmd.add_wr | cmd.fin_wr;
	assign wr_addr = cmd.add_wr ? level_q : sweep_q;

	always_comb begin
		priority if (cmd.clr_wr) wr_data = '0;
		else if (cmd.add_wr) wr_data = sat_add(rd_q, count_t'(1));
		else wr_data = acc_nxt;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Sweep counter and running cumulative sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			acc_q   <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_q <= '0;
			acc_q   <= '0;
		end else if (cmd.clr_wr || cmd.fin_wr) begin
			sweep_q <= sweep_q + 1'b1;
			acc_q   <= acc_nxt;
		end
	end

	// Integrated flag and latched total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrated_q <= 1'b0;
			total_q      <= '0;
		end else if (cmd.hist_clr) begin
			integrated_q <= 1'b0;
			total_q      <= '0;
		end else if (cmd.fin_wr && sts.sweep_last) begin
			integrated_q <= 1'b1;
			total_q      <= acc_nxt;
		end
	end

	// Restoring divider: 100 * cumulative / total, one quotient bit per cycle
	assign trial = NUM_W'(total_q) << qk_q;
	assign ge    = (rem_q >= trial);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= NUM_W'(rd_q) * NUM_W'(PCT_SCALE);
			qk_q  <= QK_W'(PCT_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_q - trial : rem_q;
			quo_q <= {quo_q[PCT_W-2:0], ge};
			qk_q  <= qk_q - 1'b1;
		end
		if (cmd.res_set) res_status_q <= cmd.res_code;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			percent_q <= (res_status_q == ST_OK) ? quo_q : '0;
			status_q  <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign percent   = percent_q;
	assign status    = status_q;

	// Status back to the controller
	assign sts.sweep_last = (sweep_q == ADDR_W'(LEVELS - 1));
	assign sts.integrated = integrated_q;
	assign sts.total_zero = (total_q == '0);
	assign sts.level_ok   = in_range;
	assign sts.div_last   = (qk_q == '0);
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

endmodule

FILE: rtl/histogram_percentile_table.sv
// Throughput: one transaction at a time, set by the sequential sweep over the bin memory
// and the one-bit-per-cycle divider; a result waits in the output register.
// Reset: runs a clearing pass over the bin memory with req_stall high;
// integrated flag and total reset to zero at once.
// Top level of the histogram percentile table.
module histogram_percentile_table import hpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          command,
	input  logic [LEVEL_W-1:0]  level,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [PCT_W-1:0]    percent,
	output logic [STATUS_W-1:0] status
);

	hpt_cmd_t cmd;
	hpt_sts_t sts;

	hpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (command),
		.sts       (sts),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	hpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.level     (level),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.percent   (percent),
		.status    (status)
	);

endmodule

FILE: rtl/hpt_checker.sv
// Port-level checker for the histogram percentile table, bound to the top level.
module hpt_checker import hpt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic [1:0]          command,
	input logic [LEVEL_W-1:0]  level,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [PCT_W-1:0]    percent,
	input logic [STATUS_W-1:0] status
);

	// A stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(percent) && $stable(status))
		else $error("result changed while stalled");

	// Percentile never exceeds 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> percent <= 7'd100)
		else $error("percent out of range");

	// Error status carries zero percent, and the status code is a defined one
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NOT_READY || status == ST_EMPTY) |-> percent == '0)
		else $error("nonzero percent with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_NOT_READY || status == ST_EMPTY))
		else $error("undefined status code");

	// A clear starts the sweep, so the request side stalls right after it
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && command == CMD_CLEAR |=> req_stall)
		else $error("no stall after clear transaction");

endmodule

bind histogram_percentile_table hpt_checker u_hpt_checker (.*);

FILE: bench/histogram_percentile_table_tb.sv
// Testbench for the histogram percentile table: directed corner cases, then random histogram rounds.
module histogram_percentile_table_tb;
	import hpt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [PCT_W-1:0] pct;
		status_t          st;
	} pct_answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [1:0]          command = CMD_CLEAR;
	logic [LEVEL_W-1:0]  level = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [PCT_W-1:0]    percent;
	logic [STATUS_W-1:0] status;

	// Shadow histogram and the answers still owed by the block
	count_t      shadow_bins [LEVELS];
	count_t      shadow_total;
	bit          shadow_integrated;
	pct_answer_t answers_due [$];

	int send_idle_pct;
	int rsp_stall_pct;
	int fail_count;

	histogram_percentile_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.level     (level),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.percent   (percent),
		.status    (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one accepted command to the shadow histogram; queue the answer of a query
	function automatic void apply_histogram_cmd(input cmd_code_t cmd, input int lvl);
		longint unsigned running;
		longint unsigned pct;
		pct_answer_t     ans;
		case (cmd)
			CMD_CLEAR: begin
				foreach (shadow_bins[i])
					shadow_bins[i] = '0;
				shadow_total = '0;
				shadow_integrated = 1'b0;
			end
			CMD_ADD: begin
				if (!shadow_integrated && shadow_bins[lvl] != count_t'(COUNT_MAX))
					shadow_bins[lvl] = shadow_bins[lvl] + count_t'(1);
			end
			CMD_FINISH: begin
				if (!shadow_integrated) begin
					for (int i = 1; i < LEVELS; i++) begin
						running = longint'(shadow_bins[i]) + longint'(shadow_bins[i-1]);
						if (running > COUNT_MAX)
							running = COUNT_MAX;
						shadow_bins[i] = count_t'(running);
					end
					shadow_total = shadow_bins[LEVELS-1];
					shadow_integrated = 1'b1;
				end
			end
			default: begin
				if (!shadow_integrated) begin
					ans.pct = '0;
					ans.st  = ST_NOT_READY;
				end else if (shadow_total == '0) begin
					ans.pct = '0;
					ans.st  = ST_EMPTY;
				end else begin
					pct = (64'd100 * longint'(shadow_bins[lvl])) / longint'(shadow_total);
					if (pct > 64'd100)
						pct = 64'd100;
					ans.pct = pct[PCT_W-1:0];
					ans.st  = ST_OK;
				end
				answers_due.push_back(ans);
			end
		endcase
	endfunction

	function automatic int any_level();
		return $urandom_range(LEVELS - 1);
	endfunction

	// Present one transaction, wait for the handshake, then update the shadow
	task automatic send_txn(input cmd_code_t cmd, input int lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		level     <= lvl[LEVEL_W-1:0];
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		apply_histogram_cmd(cmd, lvl);
	endtask

	// Response side: random stall, compare each accepted answer with the oldest one due
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		pct_answer_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result: percent %0d status %0d", percent, status);
				fail_count++;
			end else begin
				want = answers_due.pop_front();
				if (percent !== want.pct) begin
					$error("percent mismatch: expected %0d, got %0d", want.pct, percent);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status mismatch: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	// Queries while still loading, right after reset
	task automatic test_not_ready();
		send_txn(CMD_QUERY, 0);
		send_txn(CMD_QUERY, LEVELS - 1);
	endtask

	// Finish with nothing counted, finish twice, add after finish
	task automatic test_empty_histogram();
		send_txn(CMD_FINISH, 0);
		send_txn(CMD_QUERY, 5);
		send_txn(CMD_FINISH, LEVELS - 1);
		send_txn(CMD_ADD, 7);
		send_txn(CMD_QUERY, 7);
	endtask

	// Extreme and alternating-bit levels, plus ignored add and finish once integrated
	task automatic test_level_extremes();
		send_txn(CMD_CLEAR, LEVELS - 1);
		send_txn(CMD_ADD, 0);
		send_txn(CMD_ADD, 0);
		send_txn(CMD_ADD, LEVELS - 1);
		send_txn(CMD_ADD, 8191);
		send_txn(CMD_ADD, 5461);
		send_txn(CMD_ADD, 10922);
		send_txn(CMD_QUERY, 8191);
		send_txn(CMD_FINISH, 5461);
		send_txn(CMD_ADD, 0);
		send_txn(CMD_FINISH, 0);
		send_txn(CMD_QUERY, 0);
		send_txn(CMD_QUERY, LEVELS - 1);
		send_txn(CMD_QUERY, 8190);
		send_txn(CMD_QUERY, 8191);
		send_txn(CMD_QUERY, 10922);
	endtask

	// One load/finish/query round with samples clustered in a random window
	task automatic run_histogram_round();
		int n_adds;
		int n_queries;
		int span;
		int base;
		int pick;
		n_adds    = $urandom_range(20, 80);
		n_queries = $urandom_range(20, 50);
		case ($urandom_range(2))
			0: span = 16;
			1: span = 512;
			default: span = LEVELS;
		endcase
		base = $urandom_range(LEVELS - span);
		// now and then an empty histogram
		if ($urandom_range(15) == 0)
			n_adds = 0;
		// usually start fresh; sometimes keep the integrated table so adds are dropped
		if ($urandom_range(9) != 0)
			send_txn(CMD_CLEAR, any_level());
		for (int i = 0; i < n_adds; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				send_txn(CMD_ADD, base + $urandom_range(span - 1));
			else if (pick < 92)
				send_txn(CMD_ADD, any_level());
			else
				send_txn(CMD_QUERY, any_level());
		end
		send_txn(CMD_FINISH, any_level());
		if ($urandom_range(3) == 0)
			send_txn(CMD_FINISH, any_level());
		for (int i = 0; i < n_queries; i++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				send_txn(CMD_QUERY, base + $urandom_range(span - 1));
			else if (pick < 62)
				send_txn(CMD_QUERY, ($urandom_range(1) == 0) ? base : base + span - 1);
			else if (pick < 80)
				send_txn(CMD_QUERY, any_level());
			else if (pick < 90)
				send_txn(CMD_QUERY, ($urandom_range(1) == 0) ? 0 : LEVELS - 1);
			else
				send_txn(CMD_ADD, base + $urandom_range(span - 1));
		end
	endtask

	task automatic test_random_rounds(input int idle_pct, input int stall_pct, input int rounds);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int r = 0; r < rounds; r++)
			run_histogram_round();
	endtask

	// Main sequence
	initial begin
		fail_count    = 0;
		send_idle_pct = 14;
		rsp_stall_pct = 45;
		apply_histogram_cmd(CMD_CLEAR, 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_not_ready();
		test_empty_histogram();
		test_level_extremes();
		test_random_rounds(14, 45, 4);
		test_random_rounds(45, 14, 4);
		test_random_rounds(0, 0, 4);

		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("** histogram_percentile_table: PASSED **");
		end else begin
			$display("** histogram_percentile_table: FAILED **");
		end
		$finish;
	end

	// Hard limit, several times the slowest legal run
	initial begin
		#50ms;
		$display("** histogram_percentile_table: FAILED **");
		$finish;
	end

endmodule
